@@ sv/grhc_pkg.sv @@
// Shared types and constants for the gaze region hit classifier.
// Used by grhc_region_match and gaze_region_hit_classifier; no dependencies.
package grhc_pkg;

   localparam int SCENES            = 5;
   localparam int REGIONS_PER_SCENE = 8;
   localparam int COORD_BITS        = 11;
   localparam int MILESTONES        = 4;

   localparam int SCENE_W   = (SCENES > 1) ? $clog2(SCENES) : 1;
   localparam int TIME_W    = 24;
   localparam int LENGTH_W  = 24;
   localparam int STEP_W    = 16;
   localparam int HIT_W     = 16;
   localparam int REGION_W  = 4;
   localparam int MS_W      = 3;
   localparam int READY_W   = 5;
   localparam int SLOT_W    = 6;
   localparam int LVL_W     = $clog2(MILESTONES + 1);
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [TIME_W-1:0]   RST_SCENE_START    = TIME_W'(15000);
   localparam logic [LENGTH_W-1:0] RST_SCENE_LENGTH   = LENGTH_W'(2500);
   localparam logic [STEP_W-1:0]   RST_MILESTONE_STEP = STEP_W'(20);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCENE_START,
      CSR_SCENE_LENGTH,
      CSR_MILESTONE_STEP
   } csr_index_type;

   typedef enum logic {
      KIND_GAZE,
      KIND_LOAD
   } kind_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] left;
      logic [COORD_BITS-1:0] right;
      logic [COORD_BITS-1:0] top;
      logic [COORD_BITS-1:0] bottom;
   } rect_type;

   typedef struct packed {
      logic                hit;
      logic [REGION_W-1:0] region;
   } match_type;

endpackage

@@ sv/grhc_region_match.sv @@
// Priority point-in-rectangle match over one scene's row of rectangles.
// Depends on grhc_pkg for rect_type, match_type and table sizes.
module grhc_region_match
   import grhc_pkg::*;
(
   input  rect_type                     rect_row [REGIONS_PER_SCENE],
   input  logic [REGIONS_PER_SCENE-1:0] valid_row,
   input  logic [COORD_BITS-1:0]        px,
   input  logic [COORD_BITS-1:0]        py,
   output match_type                    match
);

   logic [REGIONS_PER_SCENE-1:0] inside_rect;

   always_comb begin
      for (int r = 0; r < REGIONS_PER_SCENE; r++) begin
         inside_rect[r] = valid_row[r] &&
                          (px >= rect_row[r].left) && (px <= rect_row[r].right) &&
                          (py >= rect_row[r].top)  && (py <= rect_row[r].bottom);
      end
   end

   // lowest region number wins
   always_comb begin
      match.hit    = 1'b0;
      match.region = '0;
      for (int r = REGIONS_PER_SCENE - 1; r >= 0; r--) begin
         if (inside_rect[r]) begin
            match.hit    = 1'b1;
            match.region = REGION_W'(r + 1);
         end
      end
   end

endmodule

@@ sv/gaze_region_hit_classifier.sv @@
// Gaze region hit classifier top level: handshake, scene select, table, counters.
// Depends on grhc_pkg and grhc_region_match.

// One request is accepted every cycle while req_tready is high, and each produces
// one response (input register, then result register); a stalled response blocks the
// input only once both registers are full. Requests with tuser set load one
// rectangle into the table, the others are gaze samples classified against the
// scene selected by their time. A load takes effect for the very next request.
// The rectangle table is cleared (all entries invalid) at reset with no sweep.
// CSR writes are taken whenever csr_valid is high and must only be issued while
// no request is in flight.
module gaze_region_hit_classifier
   import grhc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // time_req[23:0] x[34:24] y[45:35] scene_ready[50:46] slot[56:51] left[67:57]
   // right[78:68] top[89:79] bottom[100:90] slot_valid[101], zero pad above
   input  logic [103:0]          req_tdata,
   // kind
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // region[3:0] hit_number[19:4] milestone[22:20], zero pad above
   output logic [23:0]           rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int BOUND_W    = TIME_W + SCENE_W + 1;
   localparam int PROD_W     = STEP_W + LVL_W;
   localparam int READY_EXT  = 1 << SCENE_W;

   // configuration
   logic [TIME_W-1:0]   start_ff;
   logic [LENGTH_W-1:0] length_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [LENGTH_W-1:0] length_eff;
   logic [BOUND_W-1:0]  bound_ff [SCENES];

   // pipeline
   logic         a_valid_ff, a_valid_in;
   logic [103:0] a_data_ff;
   logic         a_kind_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [23:0]  rsp_data_ff, rsp_data_in;
   logic         rsp_free, a_advance, req_accept;

   // state
   rect_type                     tbl_rect_ff  [SCENES][REGIONS_PER_SCENE];
   logic [REGIONS_PER_SCENE-1:0] tbl_valid_ff [SCENES];
   logic [HIT_W-1:0]             cnt_ff, cnt_in;
   logic [LVL_W-1:0]             lvl_ff, lvl_in;

   // unpacked request fields
   logic [TIME_W-1:0]     f_time;
   logic [COORD_BITS-1:0] f_x, f_y;
   logic [READY_W-1:0]    f_ready;
   logic [SLOT_W-1:0]     f_slot;
   rect_type              f_rect;
   logic                  f_slot_valid;
   logic                  is_gaze, is_load;

   logic                 in_window, scene_ok;
   logic [SCENE_W-1:0]   scene_idx;
   logic [READY_EXT-1:0] ready_ext;
   match_type            match;
   logic                 hit;
   logic [REGION_W-1:0]  region;
   logic [HIT_W-1:0]     hit_number;
   logic [PROD_W-1:0]    threshold;
   logic                 ms_step;
   logic [MS_W-1:0]      milestone;

   // ---------------- CSR ----------------
   assign csr_ready  = 1'b1;
   assign length_eff = (length_ff == '0) ? LENGTH_W'(1) : length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= RST_SCENE_START;
         length_ff <= RST_SCENE_LENGTH;
         step_ff   <= RST_MILESTONE_STEP;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SCENE_START:    start_ff  <= csr_data[TIME_W-1:0];
            CSR_SCENE_LENGTH:   length_ff <= csr_data[LENGTH_W-1:0];
            CSR_MILESTONE_STEP: step_ff   <= csr_data[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // scene window start times, refreshed from the CSRs every cycle
   always_ff @(posedge clock) begin
      for (int s = 0; s < SCENES; s++) begin
         bound_ff[s] <= BOUND_W'(start_ff) + BOUND_W'(length_eff) * BOUND_W'(s);
      end
   end

   // ---------------- handshake ----------------
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign a_advance  = a_valid_ff && rsp_free;
   assign req_tready = !a_valid_ff || rsp_free;
   assign req_accept = req_tvalid && req_tready;

   assign a_valid_in   = req_accept ? 1'b1 : (a_advance ? 1'b0 : a_valid_ff);
   assign rsp_valid_in = a_advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_data_ff <= req_tdata;
         a_kind_ff <= req_tuser;
      end
      if (a_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- classification ----------------
   assign f_time       = a_data_ff[23:0];
   assign f_x          = a_data_ff[34:24];
   assign f_y          = a_data_ff[45:35];
   assign f_ready      = a_data_ff[50:46];
   assign f_slot       = a_data_ff[56:51];
   assign f_rect.left   = a_data_ff[67:57];
   assign f_rect.right  = a_data_ff[78:68];
   assign f_rect.top    = a_data_ff[89:79];
   assign f_rect.bottom = a_data_ff[100:90];
   assign f_slot_valid = a_data_ff[101];

   assign is_gaze = (kind_type'(a_kind_ff) == KIND_GAZE);
   assign is_load = (kind_type'(a_kind_ff) == KIND_LOAD);

   assign in_window = BOUND_W'(f_time) >= bound_ff[0];

   always_comb begin
      scene_idx = '0;
      for (int s = 1; s < SCENES; s++) begin
         if (BOUND_W'(f_time) >= bound_ff[s]) begin
            scene_idx = SCENE_W'(s);
         end
      end
   end

   assign ready_ext = READY_EXT'(f_ready);
   assign scene_ok  = in_window && ready_ext[scene_idx];

   grhc_region_match u_match (
      .rect_row  (tbl_rect_ff[scene_idx]),
      .valid_row (tbl_valid_ff[scene_idx]),
      .px        (f_x),
      .py        (f_y),
      .match     (match)
   );

   assign hit    = is_gaze && scene_ok && match.hit;
   assign region = hit ? match.region : '0;

   // ---------------- hit counter and milestones ----------------
   assign cnt_in     = (hit && (cnt_ff != '1)) ? cnt_ff + HIT_W'(1) : cnt_ff;
   assign hit_number = hit ? cnt_in : '0;
   assign threshold  = PROD_W'(step_ff) * PROD_W'(lvl_ff + LVL_W'(1));
   assign ms_step    = is_gaze && (lvl_ff < LVL_W'(MILESTONES)) &&
                       (PROD_W'(cnt_in) > threshold);
   assign lvl_in     = ms_step ? lvl_ff + LVL_W'(1) : lvl_ff;
   assign milestone  = ms_step ? MS_W'(lvl_in) : '0;

   assign rsp_data_in = {1'b0, milestone, hit_number, region};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         lvl_ff <= '0;
      end else if (a_advance) begin
         cnt_ff <= cnt_in;
         lvl_ff <= lvl_in;
      end
   end

   // ---------------- rectangle table ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SCENES; s++) begin
            tbl_valid_ff[s] <= '0;
         end
      end else if (a_advance && is_load) begin
         for (int s = 0; s < SCENES; s++) begin
            for (int r = 0; r < REGIONS_PER_SCENE; r++) begin
               if (int'(f_slot) == s * REGIONS_PER_SCENE + r) begin
                  tbl_valid_ff[s][r] <= f_slot_valid;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_advance && is_load) begin
         for (int s = 0; s < SCENES; s++) begin
            for (int r = 0; r < REGIONS_PER_SCENE; r++) begin
               if (int'(f_slot) == s * REGIONS_PER_SCENE + r) begin
                  tbl_rect_ff[s][r] <= f_rect;
               end
            end
         end
      end
   end

`ifndef NO_ASSERTIONS
   // a reported region always carries a nonzero hit number and vice versa
   a_region_hit : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[3:0] != '0) == (rsp_tdata[19:4] != '0)))
      else $error("region and hit_number disagree");

   // a reported milestone matches the level left behind by that request
   a_ms_level : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[22:20] != '0)) |-> (rsp_tdata[22:20] == MS_W'(lvl_ff)))
      else $error("milestone does not match level");

   // hit count never goes backward
   a_cnt_mono : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (cnt_ff >= $past(cnt_ff)))
      else $error("hit count decreased");

   // level moves by at most one per request
   a_lvl_step : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((lvl_ff == $past(lvl_ff)) ||
                         (lvl_ff == $past(lvl_ff) + LVL_W'(1))))
      else $error("milestone level jumped");
`endif

endmodule

@@ tb/grhc_hit_checker.sv @@
// Checker for the gaze region hit classifier: watches the request, response and
// CSR channels, keeps its own scene/rectangle/counter state and compares results.
// Depends on grhc_pkg.
module grhc_hit_checker
   import grhc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [103:0]          req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [23:0]           rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending,
   output int                    hit_tally,
   output int                    milestone_tally
);

   localparam int TABLE_SLOTS = SCENES * REGIONS_PER_SCENE;
   localparam int HIT_MAX     = (1 << HIT_W) - 1;

   typedef struct packed {
      logic [1:0]            pad;
      logic                  slot_valid;
      logic [COORD_BITS-1:0] bottom;
      logic [COORD_BITS-1:0] top;
      logic [COORD_BITS-1:0] right;
      logic [COORD_BITS-1:0] left;
      logic [SLOT_W-1:0]     slot;
      logic [READY_W-1:0]    ready;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] x;
      logic [TIME_W-1:0]     tick;
   } gaze_req_type;

   typedef struct packed {
      logic                pad;
      logic [MS_W-1:0]     milestone;
      logic [HIT_W-1:0]    hit_number;
      logic [REGION_W-1:0] region;
   } outcome_type;

   rect_type            rects[TABLE_SLOTS];
   logic                rect_live[TABLE_SLOTS];
   logic [TIME_W-1:0]   scene_start;
   logic [LENGTH_W-1:0] scene_len;
   logic [STEP_W-1:0]   step;
   int                  hit_count;
   int                  level;
   int                  failures = 0;
   int                  hits = 0;
   int                  milestones = 0;
   outcome_type         outcomes_due[$];

   // Applies one request to the local state and returns the response it must produce.
   function automatic outcome_type classify_sample(kind_type k, gaze_req_type f);
      outcome_type o;
      longint      span;
      int          scene;
      int          idx;
      bit          found;
      o = '0;
      scene = -1;
      found = 1'b0;
      if (k == KIND_LOAD) begin
         if (f.slot < TABLE_SLOTS) begin
            rects[f.slot] = '{left: f.left, right: f.right, top: f.top, bottom: f.bottom};
            rect_live[f.slot] = f.slot_valid;
         end
         return o;
      end
      if (f.tick >= scene_start) begin
         span = (longint'(f.tick) - longint'(scene_start)) /
                ((scene_len == 0) ? 64'sd1 : longint'(scene_len));
         scene = (span >= SCENES - 1) ? SCENES - 1 : int'(span);
      end
      if (scene >= 0 && f.ready[scene]) begin
         for (int r = 0; r < REGIONS_PER_SCENE; r++) begin
            idx = scene * REGIONS_PER_SCENE + r;
            if (!found && rect_live[idx] &&
                f.x >= rects[idx].left && f.x <= rects[idx].right &&
                f.y >= rects[idx].top && f.y <= rects[idx].bottom) begin
               found = 1'b1;
               o.region = REGION_W'(r + 1);
            end
         end
      end
      if (found) begin
         if (hit_count < HIT_MAX)
            hit_count++;
         o.hit_number = HIT_W'(hit_count);
         hits++;
      end
      if (level < MILESTONES && hit_count > int'(step) * (level + 1)) begin
         level++;
         o.milestone = MS_W'(level);
         milestones++;
      end
      return o;
   endfunction

   always @(posedge clock) begin : track
      outcome_type got;
      outcome_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            rects[i] = '0;
            rect_live[i] = 1'b0;
         end
         scene_start = RST_SCENE_START;
         scene_len = RST_SCENE_LENGTH;
         step = RST_MILESTONE_STEP;
         hit_count = 0;
         level = 0;
         outcomes_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCENE_START: begin
                  scene_start = csr_data[TIME_W-1:0];
               end
               CSR_SCENE_LENGTH: begin
                  scene_len = csr_data[LENGTH_W-1:0];
               end
               CSR_MILESTONE_STEP: begin
                  step = csr_data[STEP_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_tvalid && req_tready)
            outcomes_due.push_back(classify_sample(kind_type'(req_tuser),
                                                   gaze_req_type'(req_tdata)));
         if (rsp_tvalid && rsp_tready) begin
            got = outcome_type'(rsp_tdata);
            if (outcomes_due.size() == 0) begin
               failures++;
               $display("%0t: response with no request outstanding: region %0d hits %0d milestone %0d",
                        $time, got.region, got.hit_number, got.milestone);
            end else begin
               want = outcomes_due.pop_front();
               if (got.region !== want.region || got.hit_number !== want.hit_number ||
                   got.milestone !== want.milestone) begin
                  failures++;
                  $display("%0t: mismatch: expected region %0d hits %0d milestone %0d, got region %0d hits %0d milestone %0d",
                           $time, want.region, want.hit_number, want.milestone,
                           got.region, got.hit_number, got.milestone);
               end
            end
         end
      end
      pending <= outcomes_due.size();
      fail_count <= failures;
      hit_tally <= hits;
      milestone_tally <= milestones;
   end

endmodule

@@ tb/tb_gaze_region_hit_classifier.sv @@
// Testbench top for gaze_region_hit_classifier: clock, reset, request and CSR
// stimulus, random response stalls, watchdog and verdict.
// Depends on grhc_pkg, the block itself and grhc_hit_checker.
module tb_gaze_region_hit_classifier;
   import grhc_pkg::*;

   localparam int TABLE_SLOTS   = SCENES * REGIONS_PER_SCENE;
   localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
   localparam int TICK_MAX      = (1 << TIME_W) - 1;
   localparam int IDLE_LIMIT    = 2000;
   localparam int HIT_RUN_ITEMS = 180;

   typedef struct packed {
      logic [1:0]            pad;
      logic                  slot_valid;
      logic [COORD_BITS-1:0] bottom;
      logic [COORD_BITS-1:0] top;
      logic [COORD_BITS-1:0] right;
      logic [COORD_BITS-1:0] left;
      logic [SLOT_W-1:0]     slot;
      logic [READY_W-1:0]    ready;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] x;
      logic [TIME_W-1:0]     tick;
   } gaze_req_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [103:0]          req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int     fail_count;
   int     pending;
   int     hit_tally;
   int     milestone_tally;
   int     requests_sent = 0;
   int     settings_used = 1;
   int     idle_cycles = 0;
   int     stall_left = 0;
   logic   calm = 1'b0;
   longint cur_start = 15000;
   longint cur_len = 2500;
   int     aim_l[TABLE_SLOTS] = '{default: 1};
   int     aim_r[TABLE_SLOTS] = '{default: 0};
   int     aim_t[TABLE_SLOTS] = '{default: 1};
   int     aim_b[TABLE_SLOTS] = '{default: 0};

   gaze_region_hit_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   grhc_hit_checker hit_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .hit_tally       (hit_tally),
      .milestone_tally (milestone_tally)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // mostly short, a few long
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return $urandom_range(1, 3);
      if (r < 96)
         return $urandom_range(4, 12);
      return $urandom_range(20, 45);
   endfunction

   function automatic gaze_req_type scrambled_request();
      logic [127:0] raw;
      gaze_req_type f;
      raw = {$urandom, $urandom, $urandom, $urandom};
      f = raw[103:0];
      f.pad = '0;
      return f;
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
         rsp_tready <= 1'b0;
         stall_left <= idle_span() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_request(input kind_type k, input gaze_req_type f);
      int gap;
      gap = (calm || $urandom_range(0, 99) < 65) ? 0 : idle_span();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= k;
      req_tdata <= f;
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   function automatic void remember_rect(gaze_req_type f);
      if (f.slot < TABLE_SLOTS) begin
         aim_l[f.slot] = f.slot_valid ? int'(f.left) : 1;
         aim_r[f.slot] = f.slot_valid ? int'(f.right) : 0;
         aim_t[f.slot] = f.slot_valid ? int'(f.top) : 1;
         aim_b[f.slot] = f.slot_valid ? int'(f.bottom) : 0;
      end
   endfunction

   task automatic send_load(input int slot, input int l, input int r, input int t,
                            input int b, input bit v);
      gaze_req_type f;
      f = '0;
      f.slot = SLOT_W'(slot);
      f.left = COORD_BITS'(l);
      f.right = COORD_BITS'(r);
      f.top = COORD_BITS'(t);
      f.bottom = COORD_BITS'(b);
      f.slot_valid = v;
      remember_rect(f);
      push_request(KIND_LOAD, f);
   endtask

   task automatic send_gaze(input longint tick, input int x, input int y, input int ready);
      gaze_req_type f;
      f = '0;
      f.tick = TIME_W'(tick);
      f.x = COORD_BITS'(x);
      f.y = COORD_BITS'(y);
      f.ready = READY_W'(ready);
      push_request(KIND_GAZE, f);
   endtask

   // Picks a time tick, mostly inside a scene window and often on its edges.
   task automatic pick_tick(output longint tick, output int scene);
      int     c;
      longint span;
      longint base;
      longint off;
      c = $urandom_range(0, 99);
      scene = -1;
      span = (cur_len == 0) ? 1 : cur_len;
      if (c < 8) begin
         tick = $urandom_range(0, TICK_MAX);
      end else if (c < 16 && cur_start > 0) begin
         tick = $urandom_range(0, int'(cur_start - 1));
      end else begin
         scene = $urandom_range(0, SCENES - 1);
         base = cur_start + scene * span;
         c = $urandom_range(0, 3);
         off = (c == 0) ? 0 : (c == 1) ? span - 1 : $urandom_range(0, int'(span - 1));
         if (scene == SCENES - 1 && c == 3)
            off = off + $urandom_range(0, int'(span - 1));
         tick = (base + off) & TICK_MAX;
         if (base + off > TICK_MAX)
            scene = -1;
      end
   endtask

   task automatic random_item();
      gaze_req_type f;
      longint       tick;
      int           scene;
      int           idx;
      int           hi;
      f = scrambled_request();
      if ($urandom_range(0, 99) < 20) begin
         f.slot = ($urandom_range(0, 99) < 92) ? SLOT_W'($urandom_range(0, TABLE_SLOTS - 1)) :
                                                 SLOT_W'($urandom_range(TABLE_SLOTS, 63));
         if ($urandom_range(0, 99) < 85) begin
            hi = int'(f.left) + $urandom_range(0, 1200);
            f.right = COORD_BITS'((hi > COORD_MAX) ? COORD_MAX : hi);
            hi = int'(f.top) + $urandom_range(0, 1200);
            f.bottom = COORD_BITS'((hi > COORD_MAX) ? COORD_MAX : hi);
         end
         f.slot_valid = ($urandom_range(0, 9) != 0);
         remember_rect(f);
         push_request(KIND_LOAD, f);
      end else begin
         pick_tick(tick, scene);
         f.tick = TIME_W'(tick);
         if (scene >= 0 && $urandom_range(0, 99) < 65) begin
            idx = scene * REGIONS_PER_SCENE + $urandom_range(0, REGIONS_PER_SCENE - 1);
            if (aim_l[idx] <= aim_r[idx] && aim_t[idx] <= aim_b[idx]) begin
               f.x = COORD_BITS'($urandom_range(aim_l[idx], aim_r[idx]));
               f.y = COORD_BITS'($urandom_range(aim_t[idx], aim_b[idx]));
            end
         end
         f.ready = ($urandom_range(0, 99) < 75) ? '1 : READY_W'($urandom_range(0, 31));
         push_request(KIND_GAZE, f);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input longint start, input longint len, input longint step_word);
      longint vals[3];
      vals[0] = start;
      vals[1] = len;
      vals[2] = step_word;
      csr_valid <= 1'b1;
      for (int i = 0; i < 3; i++) begin
         csr_index <= csr_index_type'(i);
         csr_data <= CSR_DATA_W'(vals[i]);
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cur_start = start;
      cur_len = len;
      settings_used++;
   endtask

   initial begin
      int n;
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pass at reset settings: start 15000, length 2500, step 20
      send_gaze(0, 0, 0, 5'h1F);
      send_gaze(15000, 100, 100, 5'h1F);
      send_load(0, 100, 200, 100, 200, 1);
      send_load(1, 0, COORD_MAX, 0, COORD_MAX, 1);
      send_load(2, 0, COORD_MAX, 0, COORD_MAX, 0);
      send_load(8, 500, 400, 0, COORD_MAX, 1);
      send_load(9, 0, COORD_MAX, 900, 800, 1);
      send_load(10, 0, COORD_MAX, 0, COORD_MAX, 1);
      send_load(39, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1);
      send_load(40, 0, COORD_MAX, 0, COORD_MAX, 1);
      send_load(63, 0, COORD_MAX, 0, COORD_MAX, 1);
      send_gaze(15000, 100, 100, 5'h01);
      send_gaze(17499, 200, 200, 5'h01);
      send_gaze(17499, 201, 150, 5'h01);
      send_gaze(17500, 450, 850, 5'h02);
      send_gaze(17500, 450, 850, 5'h1D);
      send_gaze(25000, COORD_MAX, COORD_MAX, 5'h10);
      send_gaze(TICK_MAX, COORD_MAX, COORD_MAX, 5'h10);
      send_gaze(24999, 150, 150, 5'h1F);
      send_gaze(14999, 150, 150, 5'h1F);
      send_gaze(40000, 0, 0, 5'h00);
      send_load(0, 100, 200, 100, 200, 0);
      send_gaze(15000, 100, 100, 5'h01);

      // normal milestone crossings at the reset step
      drain();
      n = 0;
      while (hit_tally < 50 && n < 400) begin
         random_item();
         n++;
      end

      // zero length and zero step
      drain();
      set_config(0, 0, 0);
      repeat (300) random_item();

      drain();
      set_config(TICK_MAX, TICK_MAX, {8'($urandom), 16'hFFFF});
      repeat (300) random_item();

      drain();
      set_config(100, 1, 1);
      calm <= 1'b1;
      repeat (300) random_item();

      drain();
      calm <= 1'b0;
      set_config($urandom_range(0, 20000), $urandom_range(1, 5000), $urandom_range(1, 100));
      repeat (300) random_item();

      // back-to-back run of hits in the open-ended last scene
      drain();
      calm <= 1'b1;
      set_config(0, 1, 20);
      send_load((SCENES - 1) * REGIONS_PER_SCENE, 0, COORD_MAX, 0, COORD_MAX, 1);
      repeat (HIT_RUN_ITEMS)
         send_gaze($urandom_range(SCENES - 1, TICK_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, COORD_MAX), $urandom_range(0, 31) | 5'h10);

      drain();
      repeat (6) @(posedge clock);
      $display("%0d requests over %0d register settings, %0d region hits, %0d milestones",
               requests_sent, settings_used, hit_tally, milestone_tally);
      $display("scene edges, disabled/inverted rectangles, bad slots, zero step/length, hit runs");
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
